FILE: src/etvd_pkg.sv
package etvd_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int OFFSET_WIDTH        = 32;
    localparam int DEPTH_WIDTH         = 31;
    localparam int DATA_BITS           = 6;

    localparam logic [7:0] DATA_MASK = 8'h3F;
    localparam logic [7:0] MORE_FLAG = 8'h40;

    localparam logic [1:0] FIELD_START   = 2'd0;
    localparam logic [1:0] FIELD_SIZE    = 2'd1;
    localparam logic [1:0] FIELD_HANDLER = 2'd2;
    localparam logic [1:0] FIELD_DEPTH   = 2'd3;

    localparam logic STATUS_COMPLETE  = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       end_of_table;
    } t_in;

    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] try_begin;
        logic [OFFSET_WIDTH-1:0] try_end;
        logic [OFFSET_WIDTH-1:0] handler_addr;
        logic [DEPTH_WIDTH-1:0]  stack_depth;
        logic                    keep_lasti;
        logic                    status;
        logic                    table_done;
    } t_out;

endpackage

FILE: src/etvd_core.sv
module etvd_core #(
    parameter int VALUE_WIDTH = etvd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  etvd_pkg::t_in  i_data,
    output logic           o_res_valid,
    output etvd_pkg::t_out o_res
);
    import etvd_pkg::*;

    localparam int SAVE_WIDTH = (VALUE_WIDTH < OFFSET_WIDTH) ? VALUE_WIDTH : OFFSET_WIDTH;

    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [1:0]             r_field, n_field;
    logic [SAVE_WIDTH-1:0]  r_start, n_start;
    logic [SAVE_WIDTH-1:0]  r_size, n_size;
    logic [SAVE_WIDTH-1:0]  r_handler, n_handler;

    logic [VALUE_WIDTH-1:0]  acc;
    logic [7:0]              data_bits;
    logic                    more;
    logic [OFFSET_WIDTH-1:0] acc32;
    logic [OFFSET_WIDTH-1:0] s32, z32, h32;

    assign data_bits = i_data.table_byte & DATA_MASK;
    assign more      = |(i_data.table_byte & MORE_FLAG);
    assign acc       = {r_acc[VALUE_WIDTH-DATA_BITS-1:0], data_bits[DATA_BITS-1:0]};
    assign acc32     = OFFSET_WIDTH'(acc);
    assign s32       = OFFSET_WIDTH'(r_start);
    assign z32       = OFFSET_WIDTH'(r_size);
    assign h32       = OFFSET_WIDTH'(r_handler);

    always_comb begin
        n_acc       = r_acc;
        n_field     = r_field;
        n_start     = r_start;
        n_size      = r_size;
        n_handler   = r_handler;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (more) begin
                n_acc = acc;
            end else begin
                n_acc   = '0;
                n_field = r_field + 2'd1;
                case (r_field)
                    FIELD_START:   n_start   = SAVE_WIDTH'(acc);
                    FIELD_SIZE:    n_size    = SAVE_WIDTH'(acc);
                    FIELD_HANDLER: n_handler = SAVE_WIDTH'(acc);
                    default: ;
                endcase
            end
            if (!more && r_field == FIELD_DEPTH) begin
                o_res_valid        = 1'b1;
                o_res.try_begin    = s32 << 1;
                o_res.try_end      = (s32 + z32) << 1;
                o_res.handler_addr = h32 << 1;
                o_res.stack_depth  = acc32[OFFSET_WIDTH-1:1];
                o_res.keep_lasti   = acc32[0];
                o_res.status       = STATUS_COMPLETE;
                o_res.table_done   = i_data.end_of_table;
            end else if (i_data.end_of_table) begin
                o_res_valid      = 1'b1;
                o_res.status     = STATUS_TRUNCATED;
                o_res.table_done = 1'b1;
            end
            // an emitted result closes the entry or the table: start over
            if (o_res_valid) begin
                n_acc     = '0;
                n_field   = FIELD_START;
                n_start   = '0;
                n_size    = '0;
                n_handler = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_field   <= FIELD_START;
            r_start   <= '0;
            r_size    <= '0;
            r_handler <= '0;
        end else begin
            r_acc     <= n_acc;
            r_field   <= n_field;
            r_start   <= n_start;
            r_size    <= n_size;
            r_handler <= n_handler;
        end
    end

    a_res_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_accept)
        else $error("result without an input beat");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_data.end_of_table) |=> (r_field == FIELD_START && r_acc == '0))
        else $error("state not cleared after end of table");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == STATUS_TRUNCATED) |->
        (o_res.try_begin == '0 && o_res.try_end == '0 &&
         o_res.handler_addr == '0 && o_res.table_done))
        else $error("truncated result carries data");

    a_complete_on_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == STATUS_COMPLETE) |-> (r_field == FIELD_DEPTH))
        else $error("complete result outside the depth field");

endmodule

FILE: src/etvd_out_reg.sv
module etvd_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_res_valid,
    input  etvd_pkg::t_out i_res,
    output logic           o_full_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output etvd_pkg::t_out o_out_data
);
    import etvd_pkg::*;

    logic r_valid, n_valid;
    t_out r_data;

    // hold a waiting result; stall upstream only while it cannot leave
    assign o_full_stall = r_valid & i_out_stall;
    assign o_out_valid  = r_valid;
    assign o_out_data   = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_res_valid) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_data <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full_stall |-> !i_res_valid)
        else $error("result overwrote a stalled beat");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> (r_valid && $stable(r_data)))
        else $error("stalled result lost");

    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_full_stall)
        else $error("stall while output empty");

endmodule

FILE: src/exception_table_varint_decoder.sv
// Exception table varint decoder: one table byte per beat.
// A result is registered and shows on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the single output register stalls input only
// while it holds a result that the consumer stalls.
// Reset (synchronous, active low) clears the field state and empties the output.
module exception_table_varint_decoder #(
    parameter int VALUE_WIDTH = etvd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  etvd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output etvd_pkg::t_out o_out_data
);
    import etvd_pkg::*;

    logic accept;
    logic res_valid;
    t_out res;

    assign accept = i_in_valid & ~o_in_stall;

    etvd_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data     (i_in_data),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    etvd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full_stall(o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sim/exception_table_varint_decoder_tb.sv
`timescale 1ns / 1ps

module exception_table_varint_decoder_tb;
    import etvd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 900;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int   cycles = 0;
    int   beats_sent = 0;
    bit   in_calm = 1'b0;
    bit   out_calm = 1'b0;
    t_in  table_q[$];

    class exception_entry_model;
        logic [31:0] acc_word;
        logic [1:0]  field;
        logic [31:0] start_word;
        logic [31:0] size_word;
        logic [31:0] handler_word;
        t_out        pending_entries[$];
        int          errors;
        int          complete_seen;
        int          truncated_seen;

        function new();
            clear();
            errors = 0;
            complete_seen = 0;
            truncated_seen = 0;
        endfunction

        function void clear();
            acc_word = '0;
            field = FIELD_START;
            start_word = '0;
            size_word = '0;
            handler_word = '0;
        endfunction

        function void note_byte(t_in beat);
            logic [31:0] next_word;
            t_out        entry;
            next_word = (acc_word << DATA_BITS) | 32'(beat.table_byte & DATA_MASK);
            entry = '0;
            if ((beat.table_byte & MORE_FLAG) != 8'h00) begin
                acc_word = next_word;
            end else begin
                acc_word = '0;
                case (field)
                    FIELD_START:   start_word = next_word;
                    FIELD_SIZE:    size_word = next_word;
                    FIELD_HANDLER: handler_word = next_word;
                    default: begin
                        entry.try_begin = start_word << 1;
                        entry.try_end = (start_word + size_word) << 1;
                        entry.handler_addr = handler_word << 1;
                        entry.stack_depth = next_word[31:1];
                        entry.keep_lasti = next_word[0];
                        entry.status = STATUS_COMPLETE;
                        entry.table_done = beat.end_of_table;
                        pending_entries = {pending_entries, entry};
                        clear();
                        return;
                    end
                endcase
                field = field + 2'd1;
            end
            if (beat.end_of_table) begin
                entry.status = STATUS_TRUNCATED;
                entry.table_done = 1'b1;
                pending_entries = {pending_entries, entry};
                clear();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_entry(t_out got);
            t_out want;
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_entries.pop_front();
            compare_field("try_begin", want.try_begin, got.try_begin);
            compare_field("try_end", want.try_end, got.try_end);
            compare_field("handler_addr", want.handler_addr, got.handler_addr);
            compare_field("stack_depth", 32'(want.stack_depth), 32'(got.stack_depth));
            compare_field("keep_lasti", 32'(want.keep_lasti), 32'(got.keep_lasti));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("table_done", 32'(want.table_done), 32'(got.table_done));
            if (want.status == STATUS_COMPLETE) complete_seen++;
            else truncated_seen++;
        endfunction
    endclass

    exception_entry_model entries = new();

    exception_table_varint_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // consumer side: check accepted beats, stall in random bursts
    initial begin
        int  stall_left;
        bit  next_stall;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) entries.check_entry(out_data);
            if (stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end else begin
                next_stall = 1'b0;
                if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
            end
            if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
            out_stall <= next_stall;
        end
    end

    task automatic send_beat(t_in beat);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        entries.note_byte(beat);
        beats_sent++;
    endtask

    task automatic play_table(bit close);
        t_in beat;
        while (table_q.size() != 0) begin
            beat = table_q.pop_front();
            if (close && table_q.size() == 0) beat.end_of_table = 1'b1;
            send_beat(beat);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (entries.pending_entries.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic void push_raw(logic [7:0] b, logic eot);
        t_in beat;
        beat.table_byte = b;
        beat.end_of_table = eot;
        table_q = {table_q, beat};
    endfunction

    // encode most significant group first, continuation flag on all but the last
    function automatic void push_value(logic [41:0] v, int groups);
        for (int g = groups - 1; g >= 0; g--)
            push_raw({1'($urandom), (g != 0), v[g*6 +: 6]}, 1'b0);
    endfunction

    function automatic int push_entry();
        int r;
        int groups;
        int count;
        count = 0;
        for (int k = 0; k < 4; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) groups = 1;
            else if (r < 80) groups = $urandom_range(2, 3);
            else if (r < 95) groups = $urandom_range(4, 6);
            else groups = 7;
            push_value(42'({$urandom, $urandom}), groups);
            count += groups;
        end
        return count;
    endfunction

    initial begin
        int kind;
        int n_entries;
        int last_len;
        int cut;
        int tables;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero start and size, ignored bit 7, maximal single groups, lasti set
        push_raw(8'h00, 1'b0); push_raw(8'h80, 1'b0);
        push_raw(8'hBF, 1'b0); push_raw(8'h3F, 1'b0);
        play_table(1'b0);
        // overlong start wraps, last byte closes a complete entry
        for (int k = 0; k < 5; k++) push_raw(8'h7F, 1'b0);
        push_raw(8'h3F, 1'b0);
        push_raw(8'hFF, 1'b0); push_raw(8'h3F, 1'b0);
        push_raw(8'h41, 1'b0); push_raw(8'h00, 1'b0);
        push_raw(8'hC1, 1'b0); push_raw(8'h3E, 1'b0);
        play_table(1'b1);
        // table ends inside a value
        push_raw(8'h05, 1'b0); push_raw(8'h42, 1'b0);
        play_table(1'b1);
        // table ends on a field boundary
        push_raw(8'h01, 1'b0); push_raw(8'h02, 1'b0); push_raw(8'h03, 1'b0);
        play_table(1'b1);
        // one-byte table
        push_raw(8'h00, 1'b0);
        play_table(1'b1);
        // last byte still asks for more
        push_raw(8'h01, 1'b0); push_raw(8'h01, 1'b0);
        push_raw(8'h01, 1'b0); push_raw(8'h41, 1'b0);
        play_table(1'b1);
        drain();

        tables = 0;
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            in_calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 12))
                    push_raw(8'($urandom), ($urandom_range(0, 15) == 0));
            end else begin
                n_entries = $urandom_range(0, 5);
                last_len = 0;
                for (int k = 0; k < n_entries; k++) last_len = push_entry();
                if (n_entries == 0 || kind <= 2) begin
                    last_len = push_entry();
                    if (kind <= 2) begin
                        cut = $urandom_range(1, last_len - 1);
                        repeat (cut) void'(table_q.pop_back());
                    end
                end
            end
            play_table(1'b1);
            tables++;
            if (tables % 30 == 0) drain();
        end
        drain();
        repeat (5) @(posedge clk);

        $display("Covered %0d random beats in %0d tables after the directed cases.",
                 beats_sent, tables);
        $display("Checked %0d complete entries and %0d truncated tables.",
                 entries.complete_seen, entries.truncated_seen);
        if (entries.errors == 0 && entries.pending_entries.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/etvd_pkg.sv
src/etvd_core.sv
src/etvd_out_reg.sv
src/exception_table_varint_decoder.sv
sim/exception_table_varint_decoder_tb.sv
